// ===== src/residual_rms_norm_top_defines.svh =====
// Assertion macros for the residual RMS norm datapath (rrn_dp).
`ifndef RESIDUAL_RMS_NORM_TOP_DEFINES_SVH
`define RESIDUAL_RMS_NORM_TOP_DEFINES_SVH

// Checked at every edge, including reset.
`define RRN_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) cond) else $error(msg);

// Checked outside reset.
`define RRN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== src/rrn_pkg.sv =====
// -----------------------------------------------------------------------------
// rrn_pkg
// Shared types and constants of the residual RMS norm block.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrn_pkg;

  localparam int DATA_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int RLEN_W     = 7;
  localparam int CHAN_W     = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_RESIDUAL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH     = 2'd2;

  localparam logic [15:0]       RST_RESIDUAL_SCALE = 16'd4096;
  localparam logic [15:0]       RST_EPSILON        = 16'd1;
  localparam logic [RLEN_W-1:0] RST_ROW_LENGTH     = 7'd64;

  localparam int ACC_W      = 40;
  localparam int DIV_NUM_W  = 49;  // 2^48 fits
  localparam int DIV_DEN_W  = 41;  // mean + epsilon
  localparam int SQRT_W     = 50;
  localparam int RSTD_W     = 25;  // up to 2^24
  localparam int DIV_STEPS  = 49;
  localparam int SQRT_STEPS = 25;
  localparam int ITER_W     = 6;

  typedef logic signed [DATA_W-1:0] sample_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic acc;
    logic div_mean;
    logic div_recip;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic rstd_one;
    logic rstd_root;
    logic emit_rd;
    logic emit_m1;
    logic emit_m2;
    logic out_load;
    logic emit_next;
    logic row_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic row_full;
    logic ms_zero;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/rrn_ifs.sv =====
// -----------------------------------------------------------------------------
// rrn interfaces
// Valid/ready channels for channel input, results and register writes.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rrn_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [15:0]          sublayer_value;
  logic signed [15:0]          residual_value;
  logic signed [15:0]          gain;
  modport source (output valid, sublayer_value, residual_value, gain, input ready);
  modport sink   (input valid, sublayer_value, residual_value, gain, output ready);
endinterface

interface rrn_out_if;
  logic                        valid;
  logic                        ready;
  logic signed [15:0]          normalized_value;
  logic        [5:0]           channel_index;
  logic                        last_of_row;
  modport source (output valid, normalized_value, channel_index, last_of_row, input ready);
  modport sink   (input valid, normalized_value, channel_index, last_of_row, output ready);
endinterface

interface rrn_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [15:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== src/rrn_ctrl.sv =====
// -----------------------------------------------------------------------------
// rrn_ctrl
// Sequencer: per-channel intake, row statistics, emit loop.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrn_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rrn_pkg::dp_status_t st,
  output rrn_pkg::dp_cmd_t    cmd
);
  import rrn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SUM, S_ACC, S_CHK, S_DSTEP1, S_MS, S_DSTEP2,
    S_SQI, S_SQS, S_RSTD, S_RD, S_M1, S_M2, S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [ITER_W-1:0]  iter_r, iter_nxt;

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (st.row_full) begin
          cmd.div_mean = 1'b1;
          iter_nxt     = ITER_W'(DIV_STEPS - 1);
          state_nxt    = S_DSTEP1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DSTEP1: begin
        cmd.div_step = 1'b1;
        if (iter_r == '0) state_nxt = S_MS;
        else iter_nxt = iter_r - 1'b1;
      end
      S_MS: begin
        if (st.ms_zero) begin
          cmd.rstd_one = 1'b1;
          state_nxt    = S_RD;
        end else begin
          cmd.div_recip = 1'b1;
          iter_nxt      = ITER_W'(DIV_STEPS - 1);
          state_nxt     = S_DSTEP2;
        end
      end
      S_DSTEP2: begin
        cmd.div_step = 1'b1;
        if (iter_r == '0) state_nxt = S_SQI;
        else iter_nxt = iter_r - 1'b1;
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        iter_nxt      = ITER_W'(SQRT_STEPS - 1);
        state_nxt     = S_SQS;
      end
      S_SQS: begin
        cmd.sqrt_step = 1'b1;
        if (iter_r == '0) state_nxt = S_RSTD;
        else iter_nxt = iter_r - 1'b1;
      end
      S_RSTD: begin
        cmd.rstd_root = 1'b1;
        state_nxt     = S_RD;
      end
      S_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_M1;
      end
      S_M1: begin
        cmd.emit_m1 = 1'b1;
        state_nxt   = S_M2;
      end
      S_M2: begin
        cmd.emit_m2 = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.emit_last) begin
            cmd.row_clear = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

endmodule

// ===== src/rrn_dp.sv =====
// -----------------------------------------------------------------------------
// rrn_dp
// Datapath: residual add, row store, shared divider, square root, scaling.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "residual_rms_norm_top_defines.svh"

module rrn_dp #(
  parameter int ROW_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rrn_pkg::dp_cmd_t                    cmd,
  output rrn_pkg::dp_status_t                 st,
  input  rrn_pkg::sample_t                    in_sub,
  input  rrn_pkg::sample_t                    in_res,
  input  rrn_pkg::sample_t                    in_gain,
  input  logic                                cfg_we,
  input  logic [rrn_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [rrn_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rrn_pkg::sample_t                    out_value,
  output logic [rrn_pkg::CHAN_W-1:0]          out_index,
  output logic                                out_last
);
  import rrn_pkg::*;

  localparam int IDX_W = $clog2(ROW_DEPTH);
  localparam int CNT_W = $clog2(ROW_DEPTH + 1);

  // configuration
  logic [15:0]       alpha_r, eps_r;
  logic [RLEN_W-1:0] rlen_r;
  logic [CNT_W-1:0]  len_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= RST_RESIDUAL_SCALE;
      eps_r   <= RST_EPSILON;
      rlen_r  <= RST_ROW_LENGTH;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_RESIDUAL_SCALE: alpha_r <= cfg_data;
        CFG_EPSILON:        eps_r   <= cfg_data;
        CFG_ROW_LENGTH:     rlen_r  <= cfg_data[RLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rlen_r == '0) len_eff = CNT_W'(1);
    else if (int'(rlen_r) > ROW_DEPTH) len_eff = CNT_W'(ROW_DEPTH);
    else len_eff = CNT_W'(rlen_r);
  end

  // intake
  sample_t                sub_r, res_r, gain_r, sum_r;
  logic signed [32:0]     prod_r;
  logic signed [20:0]     res_scaled;
  logic signed [21:0]     sum_wide;
  logic signed [31:0]     sq_prod;
  logic [31:0]            square;
  logic [ACC_W-1:0]       acc_r;
  logic [CNT_W-1:0]       count_r;

  assign res_scaled = 21'((prod_r + 33'sd2048) >>> 12);
  assign sum_wide   = 22'(sub_r) + 22'(res_scaled);
  assign sq_prod    = sum_r * sum_r;
  assign square     = $unsigned(sq_prod);

  // row store: {sum, gain}
  logic [2*DATA_W-1:0] mem [ROW_DEPTH];
  logic [2*DATA_W-1:0] rd_r;
  logic [IDX_W-1:0]    k_r;

  always_ff @(posedge clk) begin
    if (cmd.acc) mem[count_r[IDX_W-1:0]] <= {sum_r, gain_r};
    if (cmd.emit_rd) rd_r <= mem[k_r];
  end

  // shared restoring divider
  logic [DIV_NUM_W-1:0] dvd_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   rem_r, rem_sh;
  logic                 rem_ge;
  logic [DIV_DEN_W-1:0] ms;

  assign rem_sh = {rem_r[DIV_DEN_W-1:0], dvd_r[DIV_NUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, den_r});
  assign ms     = DIV_DEN_W'(dvd_r[ACC_W-1:0]) + DIV_DEN_W'(eps_r);

  // square root, one result bit per step
  logic [SQRT_W-1:0] sq_n_r, sq_root_r, sq_bit_r, sq_try;
  logic [RSTD_W-1:0] rstd_r;

  assign sq_try = sq_root_r + sq_bit_r;

  // scaling
  logic signed [41:0] p1_r;
  logic signed [57:0] p2_r;
  logic signed [33:0] p_rnd;
  sample_t            p_sat;

  assign p_rnd = 34'((p2_r + 58'sd8388608) >>> 24);
  always_comb begin
    if (p_rnd > 34'sd32767) p_sat = 16'sh7fff;
    else if (p_rnd < -34'sd32768) p_sat = 16'sh8000;
    else p_sat = p_rnd[15:0];
  end

  logic out_valid_r;
  logic emit_last;

  assign emit_last = (CNT_W'(k_r) + 1'b1) == count_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sub_r  <= in_sub;
      res_r  <= in_res;
      gain_r <= in_gain;
    end
    if (cmd.mul) prod_r <= res_r * $signed({1'b0, alpha_r});
    if (cmd.sum) begin
      if (sum_wide > 22'sd32767) sum_r <= 16'sh7fff;
      else if (sum_wide < -22'sd32768) sum_r <= 16'sh8000;
      else sum_r <= sum_wide[15:0];
    end
    if (cmd.div_mean) begin
      dvd_r <= DIV_NUM_W'(acc_r);
      den_r <= DIV_DEN_W'(count_r);
      rem_r <= '0;
    end else if (cmd.div_recip) begin
      dvd_r <= DIV_NUM_W'(1) << 48;
      den_r <= ms;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      dvd_r <= {dvd_r[DIV_NUM_W-2:0], rem_ge};
    end
    if (cmd.sqrt_init) begin
      sq_n_r    <= SQRT_W'(dvd_r);
      sq_root_r <= '0;
      sq_bit_r  <= SQRT_W'(1) << 48;
    end else if (cmd.sqrt_step) begin
      if (sq_n_r >= sq_try) begin
        sq_n_r    <= sq_n_r - sq_try;
        sq_root_r <= (sq_root_r >> 1) + sq_bit_r;
      end else begin
        sq_root_r <= sq_root_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
    if (cmd.rstd_one) rstd_r <= RSTD_W'(1) << 24;
    else if (cmd.rstd_root) rstd_r <= sq_root_r[RSTD_W-1:0];
    if (cmd.emit_m1) p1_r <= $signed(rd_r[2*DATA_W-1:DATA_W]) * $signed({1'b0, rstd_r});
    if (cmd.emit_m2) p2_r <= p1_r * $signed(rd_r[DATA_W-1:0]);
    if (cmd.out_load) begin
      out_value <= p_sat;
      out_index <= CHAN_W'(k_r);
      out_last  <= emit_last;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.row_clear) begin
        acc_r   <= '0;
        count_r <= '0;
        k_r     <= '0;
      end else begin
        if (cmd.acc) begin
          acc_r   <= acc_r + ACC_W'(square);
          count_r <= count_r + 1'b1;
        end
        if (cmd.emit_next) k_r <= k_r + 1'b1;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign st.row_full  = (count_r >= len_eff);
  assign st.ms_zero   = (ms == '0);
  assign st.emit_last = emit_last;
  assign st.out_free  = !out_valid_r || out_ready;

  `RRN_ASSERT(a_count_bound, count_r <= CNT_W'(ROW_DEPTH), "row count beyond store depth")
  `RRN_ASSERT(a_out_no_overwrite, cmd.out_load |-> st.out_free, "result overwritten")
  `RRN_ASSERT(a_emit_nonempty, cmd.emit_rd |-> (count_r != '0), "emit on empty row")
  `RRN_ASSERT(a_clear_after_last, cmd.row_clear |=> (count_r == '0 && k_r == '0), "row not cleared")

endmodule

// ===== src/residual_rms_norm_top.sv =====
// -----------------------------------------------------------------------------
// residual_rms_norm_top
// Fused residual add and RMS normalization over one row of channels.
// -----------------------------------------------------------------------------
// Each input request carries one channel (sublayer, residual, gain, all Q8.8).
// The block forms sublayer + residual*alpha (alpha Q4.12, rounded, saturated),
// stores it with the gain and accumulates its square. Each channel passes
// multiply, add, square-accumulate and row check before the next is taken.
// When row_length channels are in, one shared bit-serial divider computes
// the mean square and then 2^48/(mean+eps), a digit-serial square root gives
// rstd, then each stored channel is emitted through a store read, two
// registered multiplies and a round/saturate step. Results carry the
// channel index and a last-of-row flag; the result register lets the next
// row's intake start while the final result waits to be taken.
// Registers: 0 residual_scale, 1 epsilon, 2 row_length (0 acts as 1,
// above ROW_DEPTH acts as ROW_DEPTH). Write them only while idle.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module residual_rms_norm_top #(
  parameter int ROW_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  rrn_in_if.sink     in_chan,
  rrn_out_if.source  out_chan,
  rrn_cfg_if.sink    cfg_chan
);
  import rrn_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       in_ready;

  // register writes are always taken
  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = in_ready;

  rrn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rrn_dp #(
    .ROW_DEPTH (ROW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_sub    (in_chan.sublayer_value),
    .in_res    (in_chan.residual_value),
    .in_gain   (in_chan.gain),
    .cfg_we    (cfg_chan.valid),
    .cfg_addr  (cfg_chan.addr),
    .cfg_data  (cfg_chan.data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_value (out_chan.normalized_value),
    .out_index (out_chan.channel_index),
    .out_last  (out_chan.last_of_row)
  );

endmodule

// ===== tb/tb_top.sv =====
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for residual_rms_norm_top.
// -----------------------------------------------------------------------------
// Channels stream in as bursty requests. A bit-accurate row normalizer in the
// bench predicts every result when its row closes. Results are compared
// in order against that prediction while the receiver stalls on a
// pattern of its own. Register writes happen only while the block is idle.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import rrn_pkg::*;

  localparam int ROW_DEPTH   = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;

  typedef struct {
    sample_t sublayer;
    sample_t residual;
    sample_t gain;
  } chan_req_t;

  typedef struct {
    sample_t           value;
    logic [CHAN_W-1:0] index;
    logic              last;
  } norm_res_t;

  logic clk;
  logic rst_n;

  rrn_in_if  in_if ();
  rrn_out_if out_if ();
  rrn_cfg_if cfg_if ();

  residual_rms_norm_top #(.ROW_DEPTH(ROW_DEPTH)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Bench copy of the block state and registers.
  logic [15:0]       alpha_q412;
  logic [15:0]       eps_q1616;
  logic [RLEN_W-1:0] row_len_reg;
  sample_t           sum_mem  [ROW_DEPTH];
  sample_t           gain_mem [ROW_DEPTH];
  logic [ACC_W-1:0]  sq_acc;
  int                chan_cnt;

  chan_req_t pending_reqs[$];
  norm_res_t expected_norm[$];

  int  fail_cnt;
  int  results_checked;
  int  rows_closed;
  int  reqs_sent;
  int  cfg_writes;
  int  cycle_cnt;
  logic in_taken;

  // ---------------------------------------------------------------------------
  // Arithmetic helpers
  // ---------------------------------------------------------------------------
  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Takes one accepted channel; when the row closes, queues its whole output.
  task automatic absorb_channel(chan_req_t r);
    int              len;
    longint          s;
    longint          p;
    longint unsigned mean_sq;
    longint unsigned rstd;
    norm_res_t       e;
    len = (row_len_reg == 0) ? 1 : ((row_len_reg > ROW_DEPTH) ? ROW_DEPTH : row_len_reg);
    // >>> on a signed longint floors, matching the rounding of the residual term
    s = sat16(longint'(r.sublayer)
              + ((longint'(r.residual) * longint'(alpha_q412) + 2048) >>> 12));
    if (chan_cnt >= ROW_DEPTH) chan_cnt = ROW_DEPTH - 1;
    sum_mem[chan_cnt]  = sample_t'(s);
    gain_mem[chan_cnt] = r.gain;
    sq_acc   = sq_acc + ACC_W'(s * s);
    chan_cnt = chan_cnt + 1;
    if (chan_cnt < len) return;
    mean_sq = longint'(sq_acc) / chan_cnt + eps_q1616;
    // zero mean square: rstd pinned to its value at ms = 1
    rstd = (mean_sq == 0) ? (64'd1 << 24) : int_sqrt((64'd1 << 48) / mean_sq);
    for (int k = 0; k < chan_cnt; k++) begin
      p = longint'(sum_mem[k]) * longint'(rstd) * longint'(gain_mem[k]);
      e.value = sample_t'(sat16((p + (64'sd1 << 23)) >>> 24));
      e.index = CHAN_W'(k);
      e.last  = (k + 1 == chan_cnt);
      expected_norm = {expected_norm, e};
    end
    rows_closed++;
    sq_acc   = '0;
    chan_cnt = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_norm.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Channel driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(negedge clk) begin
    chan_req_t r;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_if.valid          <= 1'b1;
        in_if.sublayer_value <= r.sublayer;
        in_if.residual_value <= r.residual;
        in_if.gain           <= r.gain;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          // one burst in three, chosen at random, runs back to back with no gap
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Accepted channel goes straight into the predictor.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      chan_req_t r;
      r.sublayer = in_if.sublayer_value;
      r.residual = in_if.residual_value;
      r.gain     = in_if.gain;
      absorb_channel(r);
      reqs_sent++;
      in_taken = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern rotates through open,
  // coin flip and long stalls
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    case ((cycle_cnt / 64) % 3)
      0: begin
        out_if.ready <= 1'b1;
      end
      1: begin
        out_if.ready <= $urandom_range(0, 1);
      end
      default: begin
        out_if.ready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    norm_res_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_norm.size() == 0) begin
        $display("%0t: unexpected result value=%0d index=%0d last=%0b", $time,
                 out_if.normalized_value, out_if.channel_index, out_if.last_of_row);
        fail_cnt++;
      end else begin
        e = expected_norm.pop_front();
        results_checked++;
        if (out_if.normalized_value !== e.value) begin
          $display("%0t: normalized_value expected %0d actual %0d (index %0d)", $time,
                   e.value, out_if.normalized_value, e.index);
          fail_cnt++;
        end
        if (out_if.channel_index !== e.index) begin
          $display("%0t: channel_index expected %0d actual %0d", $time,
                   e.index, out_if.channel_index);
          fail_cnt++;
        end
        if (out_if.last_of_row !== e.last) begin
          $display("%0t: last_of_row expected %0b actual %0b (index %0d)", $time,
                   e.last, out_if.last_of_row, e.index);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_RESIDUAL_SCALE: alpha_q412  = val;
      CFG_EPSILON:        eps_q1616   = val;
      CFG_ROW_LENGTH:     row_len_reg = val[RLEN_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic queue_chan(int sub, int res, int gn);
    chan_req_t r;
    r.sublayer = sample_t'(sub);
    r.residual = sample_t'(res);
    r.gain     = sample_t'(gn);
    pending_reqs = {pending_reqs, r};
  endtask

  // Block is idle once nothing is queued, in flight or owed.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || in_if.valid || expected_norm.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic int rand_sample();
    // half full-range, half near zero so results stay off the rails
    if ($urandom_range(0, 1)) return int'(sample_t'($urandom()));
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int len;
    int rows;
    int rand_reqs;
    bit zero_row;
    bit big_done;

    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.sublayer_value = '0;
    in_if.residual_value = '0;
    in_if.gain   = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.addr  = CFG_RESIDUAL_SCALE;
    cfg_if.data  = '0;
    in_taken     = 1'b0;
    burst_left   = 0;
    gap_left     = 0;
    fail_cnt     = 0;
    results_checked = 0;
    rows_closed  = 0;
    reqs_sent    = 0;
    cfg_writes   = 0;
    cycle_cnt    = 0;
    alpha_q412   = RST_RESIDUAL_SCALE;
    eps_q1616    = RST_EPSILON;
    row_len_reg  = RST_ROW_LENGTH;
    sq_acc       = '0;
    chan_cnt     = 0;
    foreach (sum_mem[i]) begin
      sum_mem[i]  = '0;
      gain_mem[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Field extremes at unit alpha.
    write_reg(CFG_ROW_LENGTH, 16'd4);
    queue_chan(32767, 32767, 32767);
    queue_chan(-32768, -32768, -32768);
    queue_chan(0, 0, 1);
    queue_chan(1, -1, -32768);
    wait_idle();

    // All-zero row with zero epsilon: mean square is zero.
    write_reg(CFG_EPSILON, 16'd0);
    write_reg(CFG_ROW_LENGTH, 16'd2);
    queue_chan(0, 0, 5);
    queue_chan(0, 0, -5);
    wait_idle();

    // Row length zero acts as one.
    write_reg(CFG_ROW_LENGTH, 16'd0);
    queue_chan(256, 0, 256);
    queue_chan(-256, 128, -1);
    wait_idle();

    // Largest alpha and epsilon.
    write_reg(CFG_RESIDUAL_SCALE, 16'hFFFF);
    write_reg(CFG_EPSILON, 16'hFFFF);
    write_reg(CFG_ROW_LENGTH, 16'd3);
    queue_chan(100, 32767, 256);
    queue_chan(-100, -32768, -256);
    queue_chan(5, 7, 32767);
    wait_idle();

    // Zero alpha; length lowered mid-row closes the row with all six stored.
    write_reg(CFG_RESIDUAL_SCALE, 16'd0);
    write_reg(CFG_EPSILON, 16'd1);
    write_reg(CFG_ROW_LENGTH, 16'd8);
    for (int i = 0; i < 5; i++) queue_chan(rand_sample(), rand_sample(), rand_sample());
    wait_idle();
    write_reg(CFG_ROW_LENGTH, 16'd3);
    queue_chan(300, -300, 512);
    wait_idle();

    // Random phases: mostly short rows, one full-depth row via an
    // over-range length.
    rand_reqs = 0;
    big_done  = 1'b0;
    while (rand_reqs < 160) begin
      case ($urandom_range(0, 3))
        0: write_reg(CFG_RESIDUAL_SCALE, 16'd4096);
        1: write_reg(CFG_RESIDUAL_SCALE, ($urandom_range(0, 1) ? 16'hFFFF : 16'd0));
        default: write_reg(CFG_RESIDUAL_SCALE, 16'($urandom()));
      endcase
      zero_row = ($urandom_range(0, 9) == 0);
      if (zero_row) write_reg(CFG_EPSILON, 16'd0);
      else if ($urandom_range(0, 3) == 0) write_reg(CFG_EPSILON, 16'hFFFF);
      else write_reg(CFG_EPSILON, 16'($urandom()));
      if (!big_done && rand_reqs > 60) begin
        write_reg(CFG_ROW_LENGTH, 16'd127);
        len  = ROW_DEPTH;
        rows = 1;
        big_done = 1'b1;
      end else begin
        len  = $urandom_range(1, 12);
        rows = $urandom_range(1, 3);
        write_reg(CFG_ROW_LENGTH, 16'(len));
      end
      for (int i = 0; i < len * rows; i++) begin
        if (zero_row) queue_chan(0, 0, rand_sample());
        else queue_chan(rand_sample(), rand_sample(), rand_sample());
      end
      rand_reqs += len * rows;
      wait_idle();
    end

    $display("Sent %0d channel requests in %0d rows over %0d register writes;",
             reqs_sent, rows_closed, cfg_writes);
    $display("checked %0d results, %0d mismatches.", results_checked, fail_cnt);
    if (expected_norm.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_norm.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
